// File: rtl/macroblock_neighbour_locator_unit_defines.svh
// ----------------------------------------------------------------------------
// Macroblock neighbour locator assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MACROBLOCK_NEIGHBOUR_LOCATOR_UNIT_DEFINES_SVH
`define MACROBLOCK_NEIGHBOUR_LOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MNL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MNL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define MNL_ASSERT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mnl_pkg.sv
// ----------------------------------------------------------------------------
// Macroblock neighbour locator package
// Shared codes, widths and the word types passed between the units.
// ----------------------------------------------------------------------------
package mnl_pkg;

    // Input kind codes.
    localparam logic [1:0] KIND_PIX = 2'd0;
    localparam logic [1:0] KIND_BLK = 2'd1;
    localparam logic [1:0] KIND_WR  = 2'd2;

    // Prediction direction codes.
    localparam logic [1:0] DIR_FWD = 2'd0;
    localparam logic [1:0] DIR_BWD = 2'd1;
    localparam logic [1:0] DIR_SYM = 2'd2;

    // Fixed field widths.
    localparam int ADDR_W = 13;
    localparam int POSX_W = 12;
    localparam int POSY_W = 17;

    // Queue between front and back, and the result buffer (powers of two).
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 16;

    // One input word with its fields unpacked (kind travels separately).
    typedef struct packed {
        logic [ADDR_W-1:0] cur_mb_addr;
        logic signed [5:0] x_pos;
        logic signed [5:0] y_pos;
        logic [1:0]        block8_index;
        logic              is_luma;
        logic [ADDR_W-1:0] left_addr;
        logic [ADDR_W-1:0] up_addr;
        logic [ADDR_W-1:0] upleft_addr;
        logic [ADDR_W-1:0] upright_addr;
        logic [3:0]        avail_mask;
        logic [1:0]        pdir_value;
    } t_query;

    // Classified job handed from the front to the back.
    typedef struct packed {
        logic              has_res;
        logic              is_write;
        logic              blk;
        logic              luma;
        logic              avail;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        xi;
        logic [3:0]        yi;
        logic [ADDR_W-1:0] cur;
        logic [1:0]        b8;
        logic [1:0]        pdir;
    } t_job;

    // One result word.
    typedef struct packed {
        logic              available;
        logic [ADDR_W-1:0] nb_mb_addr;
        logic [3:0]        x_in_mb;
        logic [3:0]        y_in_mb;
        logic [POSX_W-1:0] pos_x;
        logic [POSY_W-1:0] pos_y;
    } t_result;

endpackage

// File: rtl/mnl_front.sv
// ----------------------------------------------------------------------------
// Macroblock neighbour locator front end
// Accepts input words, selects the neighbour macroblock and its availability,
// and registers a classified job for the queue.
// ----------------------------------------------------------------------------
module mnl_front
    import mnl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  t_query     i_query,
    output logic       o_valid,
    output t_job       o_job,
    input  logic       i_ready
);

    logic              r_valid;
    t_job              r_job;
    t_job              n_job;
    logic              w_keep;
    logic              w_blk;
    logic              w_luma;
    logic signed [6:0] w_x;
    logic signed [6:0] w_y;
    logic signed [6:0] w_ext;
    logic              w_negx;
    logic              w_negy;
    logic              w_inx;
    logic              w_iny;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    // Offsets, extent and neighbour selection.
    always_comb begin
        w_blk  = (i_kind == KIND_BLK);
        w_luma = w_blk || i_query.is_luma;
        w_x    = {i_query.x_pos[5], i_query.x_pos}
                 + ((w_blk && i_query.block8_index[0]) ? 7'sd8 : 7'sd0);
        w_y    = {i_query.y_pos[5], i_query.y_pos}
                 + ((w_blk && i_query.block8_index[1]) ? 7'sd8 : 7'sd0);
        w_ext  = w_luma ? 7'sd16 : 7'sd8;
        w_negx = w_x[6];
        w_negy = w_y[6];
        w_inx  = !w_negx && (w_x < w_ext);
        w_iny  = !w_negy && (w_y < w_ext);

        n_job          = '0;
        n_job.blk      = w_blk;
        n_job.luma     = w_luma;
        n_job.cur      = i_query.cur_mb_addr;
        n_job.b8       = i_query.block8_index;
        n_job.pdir     = i_query.pdir_value;
        n_job.xi       = w_luma ? w_x[3:0] : {1'b0, w_x[2:0]};
        n_job.yi       = w_luma ? w_y[3:0] : {1'b0, w_y[2:0]};

        if (w_negx && w_negy) begin
            n_job.addr  = i_query.upleft_addr;
            n_job.avail = i_query.avail_mask[3];
        end else if (w_negx && (w_negy || w_iny)) begin
            n_job.addr  = i_query.left_addr;
            n_job.avail = i_query.avail_mask[0];
        end else if (w_inx && w_negy) begin
            n_job.addr  = i_query.up_addr;
            n_job.avail = i_query.avail_mask[1];
        end else if (w_inx && w_iny) begin
            n_job.addr  = i_query.cur_mb_addr;
            n_job.avail = 1'b1;
        end else if (w_negy) begin
            n_job.addr  = i_query.upright_addr;
            n_job.avail = i_query.avail_mask[2];
        end else begin
            n_job.addr  = '0;
            n_job.avail = 1'b0;
        end

        case (i_kind)
            KIND_PIX, KIND_BLK: begin
                n_job.has_res = 1'b1;
            end
            KIND_WR: begin
                n_job.is_write = 1'b1;
            end
            default: begin
                n_job.has_res = 1'b0;
            end
        endcase
        w_keep = n_job.has_res || n_job.is_write;
    end

    // Job register valid flag; unused kinds are dropped here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

// File: rtl/mnl_queue.sv
// ----------------------------------------------------------------------------
// Macroblock neighbour locator job queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module mnl_queue
    import mnl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push_job,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop_job,
    input  logic i_pop
);

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_job           r_mem [0:QUEUE_DEPTH-1];
    logic [QPW-1:0] r_wr;
    logic [QPW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic           w_push;

    assign o_push_ready = (r_count < QCW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

// File: rtl/mnl_back.sv
// ----------------------------------------------------------------------------
// Macroblock neighbour locator back end
// Holds the direction store, divides the neighbour address by the picture
// width in a pipeline of restoring steps and buffers the results.
// ----------------------------------------------------------------------------
module mnl_back
    import mnl_pkg::*;
#(
    parameter int MAX_MBS       = 8192,
    parameter int MAX_WIDTH_MBS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [8:0] i_pic_width,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    output logic       o_res_valid,
    output t_result    o_res,
    input  logic       i_res_ready
);

    localparam int DEPTH = MAX_MBS * 4;
    localparam int IDXW  = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH_MBS + 1);
    localparam int NST   = ADDR_W;
    localparam int IFW   = $clog2(NST + 2);
    localparam int OCW   = $clog2(OUT_DEPTH + 1);
    localparam int OPW   = $clog2(OUT_DEPTH);
    localparam int PXW   = WW + 4;

    // Macroblock address modulo the store size, by conditional subtraction.
    function automatic logic [ADDR_W-1:0] f_wrap(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = a;
        for (int k = ADDR_W - 1; k >= 0; k--) begin
            if (32'(r) >= (MAX_MBS << k)) begin
                r = r - ADDR_W'(MAX_MBS << k);
            end
        end
        return r;
    endfunction

    function automatic logic [IDXW-1:0] f_idx(input logic [ADDR_W-1:0] a,
                                               input logic [1:0] b);
        return IDXW'({f_wrap(a), b});
    endfunction

    logic [1:0]        r_store [0:DEPTH-1];
    logic [1:0]        r_rd_p;
    logic [1:0]        r_rd_q;
    logic [IDXW-1:0]   w_idx_p;
    logic [IDXW-1:0]   w_idx_q;
    logic [WW-1:0]     w_div;

    logic              r_dv_valid [0:NST];
    t_job              r_dv_job   [0:NST];
    logic [WW-1:0]     r_dv_rem   [0:NST];
    logic [ADDR_W-1:0] r_dv_num   [0:NST];
    logic [ADDR_W-1:0] r_dv_quo   [0:NST];
    logic [1:0]        r_dv_p     [1:NST];
    logic [1:0]        r_dv_q     [1:NST];
    logic [WW:0]       w_trial    [1:NST];
    logic              w_ge       [1:NST];

    logic [IFW-1:0]    r_inflight;
    logic [OCW-1:0]    r_ocount;
    logic [OPW-1:0]    r_owr;
    logic [OPW-1:0]    r_ord;
    t_result           r_ofifo [0:OUT_DEPTH-1];
    logic [OCW:0]      w_used;
    logic              w_credit;
    logic              w_start;
    logic              w_push;
    logic              w_opop;

    t_job              w_fj;
    logic              w_conflict;
    logic              w_av;
    logic [PXW-1:0]    w_px;
    logic [POSY_W-1:0] w_py;
    t_result           w_res;

    // Divisor: the width register held to the range one to the maximum.
    always_comb begin
        if (i_pic_width == '0) begin
            w_div = WW'(1);
        end else if (32'(i_pic_width) > MAX_WIDTH_MBS) begin
            w_div = WW'(MAX_WIDTH_MBS);
        end else begin
            w_div = WW'(i_pic_width);
        end
    end

    // A query is taken from the queue only when the result buffer has room
    // for everything already in the pipeline; writes need no room.
    assign w_used   = (OCW+1)'(r_inflight) + (OCW+1)'(r_ocount);
    assign w_credit = (w_used < (OCW+1)'(OUT_DEPTH));
    assign o_q_pop  = i_q_valid && (!i_q_job.has_res || w_credit);
    assign w_start  = o_q_pop && i_q_job.has_res;

    assign w_idx_p  = f_idx(i_q_job.cur, i_q_job.b8);
    assign w_idx_q  = f_idx(i_q_job.addr, {i_q_job.yi[3], i_q_job.xi[3]});

    // Direction store: one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_job.is_write) begin
            r_store[w_idx_p] <= i_q_job.pdir;
        end
        r_rd_p <= r_store[w_idx_p];
        r_rd_q <= r_store[w_idx_q];
    end

    // One restoring division step per stage.
    always_comb begin
        for (int k = 1; k <= NST; k++) begin
            w_trial[k] = {r_dv_rem[k-1], r_dv_num[k-1][ADDR_W-1]};
            w_ge[k]    = (w_trial[k] >= {1'b0, w_div});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else begin
            r_dv_valid[0] <= w_start;
            for (int k = 1; k <= NST; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_job[0] <= i_q_job;
        r_dv_num[0] <= i_q_job.addr;
        r_dv_rem[0] <= '0;
        r_dv_quo[0] <= '0;
        r_dv_p[1]   <= r_rd_p;
        r_dv_q[1]   <= r_rd_q;
        for (int k = 1; k <= NST; k++) begin
            r_dv_job[k] <= r_dv_job[k-1];
            r_dv_num[k] <= r_dv_num[k-1] << 1;
            r_dv_quo[k] <= {r_dv_quo[k-1][ADDR_W-2:0], w_ge[k]};
            r_dv_rem[k] <= w_ge[k] ? WW'(w_trial[k] - {1'b0, w_div}) : WW'(w_trial[k]);
        end
        for (int k = 2; k <= NST; k++) begin
            r_dv_p[k] <= r_dv_p[k-1];
            r_dv_q[k] <= r_dv_q[k-1];
        end
    end

    // Result assembly from remainder (column) and quotient (row).
    always_comb begin
        w_fj       = r_dv_job[NST];
        w_conflict = ((r_dv_p[NST] == DIR_FWD) && (r_dv_q[NST] == DIR_BWD))
                  || ((r_dv_p[NST] == DIR_BWD) && (r_dv_q[NST] == DIR_FWD))
                  || ((r_dv_p[NST] == DIR_SYM) && (r_dv_q[NST] == DIR_BWD))
                  || ((r_dv_p[NST] == DIR_BWD) && (r_dv_q[NST] == DIR_SYM));
        w_av       = w_fj.avail && !(w_fj.blk && w_conflict);
        if (w_fj.luma) begin
            w_px = {r_dv_rem[NST], 4'b0000} + PXW'(w_fj.xi);
            w_py = {r_dv_quo[NST], 4'b0000} + POSY_W'(w_fj.yi);
        end else begin
            w_px = {1'b0, r_dv_rem[NST], 3'b000} + PXW'(w_fj.xi);
            w_py = {1'b0, r_dv_quo[NST], 3'b000} + POSY_W'(w_fj.yi);
        end
        w_res = '0;
        if (w_av) begin
            w_res.available  = 1'b1;
            w_res.nb_mb_addr = w_fj.addr;
            if (w_fj.blk) begin
                w_res.x_in_mb = {3'b000, w_fj.xi[3]};
                w_res.y_in_mb = {3'b000, w_fj.yi[3]};
                w_res.pos_x   = POSX_W'(w_px >> 3);
                w_res.pos_y   = w_py >> 3;
            end else begin
                w_res.x_in_mb = w_fj.xi;
                w_res.y_in_mb = w_fj.yi;
                w_res.pos_x   = POSX_W'(w_px);
                w_res.pos_y   = w_py;
            end
        end
    end

    // Result buffer and in-flight count.
    assign w_push      = r_dv_valid[NST];
    assign o_res_valid = (r_ocount != '0);
    assign o_res       = r_ofifo[r_ord];
    assign w_opop      = o_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_ocount   <= '0;
            r_owr      <= '0;
            r_ord      <= '0;
        end else begin
            if (w_start && !w_push) begin
                r_inflight <= r_inflight + 1'b1;
            end else if (!w_start && w_push) begin
                r_inflight <= r_inflight - 1'b1;
            end
            if (w_push && !w_opop) begin
                r_ocount <= r_ocount + 1'b1;
            end else if (!w_push && w_opop) begin
                r_ocount <= r_ocount - 1'b1;
            end
            if (w_push) begin
                r_owr <= r_owr + 1'b1;
            end
            if (w_opop) begin
                r_ord <= r_ord + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ofifo[r_owr] <= w_res;
        end
    end

endmodule

// File: rtl/macroblock_neighbour_locator_unit.sv
// ----------------------------------------------------------------------------
// Macroblock neighbour locator unit
// Finds the neighbour macroblock of a sample or 8x8 block position and keeps
// the prediction-direction store used by the 8x8 conflict check.
// ----------------------------------------------------------------------------
// The unit takes one input word per cycle and returns one result word for each
// pixel or 8x8 query; direction writes and unused kinds give no result. Each
// query passes the front register, the job queue and the thirteen-stage address
// divider of the back end on its way to the result buffer; throughput stays at one
// word per cycle as long as results are taken. Results keep input order, and a
// direction write is seen by every query accepted after it. The width register
// may be written only while the unit is idle.
// ----------------------------------------------------------------------------
module macroblock_neighbour_locator_unit
    import mnl_pkg::*;
#(
    parameter int MAX_MBS       = 8192,
    parameter int MAX_WIDTH_MBS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: picture width in macroblocks.
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cur_mb_addr[12:0], x_pos[18:13], y_pos[24:19], block8_index[26:25],
    // is_luma[27], left_addr[40:28], up_addr[53:41], upleft_addr[66:54],
    // upright_addr[79:67], avail_mask[83:80], pdir_value[85:84], zero[87:86]
    input  logic [87:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // nb_mb_addr[12:0], x_in_mb[16:13], y_in_mb[20:17], pos_x[32:21],
    // pos_y[49:33], zero[55:50]
    output logic [55:0] m_axis_tdata,
    // available[0]
    output logic [0:0]  m_axis_tuser
);

    logic [8:0] r_pic_width;
    t_query     w_query;
    logic       w_f_valid;
    t_job       w_f_job;
    logic       w_f_ready;
    logic       w_q_valid;
    t_job       w_q_job;
    logic       w_q_pop;
    t_result    w_res;

    // Width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pic_width <= 9'd120;
        end else if (i_cfg_we) begin
            r_pic_width <= i_cfg_wdata;
        end
    end

    // Input word unpacking.
    always_comb begin
        w_query.cur_mb_addr  = s_axis_tdata[12:0];
        w_query.x_pos        = s_axis_tdata[18:13];
        w_query.y_pos        = s_axis_tdata[24:19];
        w_query.block8_index = s_axis_tdata[26:25];
        w_query.is_luma      = s_axis_tdata[27];
        w_query.left_addr    = s_axis_tdata[40:28];
        w_query.up_addr      = s_axis_tdata[53:41];
        w_query.upleft_addr  = s_axis_tdata[66:54];
        w_query.upright_addr = s_axis_tdata[79:67];
        w_query.avail_mask   = s_axis_tdata[83:80];
        w_query.pdir_value   = s_axis_tdata[85:84];
    end

    mnl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_query (w_query),
        .o_valid (w_f_valid),
        .o_job   (w_f_job),
        .i_ready (w_f_ready)
    );

    mnl_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .i_push_job   (w_f_job),
        .o_push_ready (w_f_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_job    (w_q_job),
        .i_pop        (w_q_pop)
    );

    mnl_back #(
        .MAX_MBS       (MAX_MBS),
        .MAX_WIDTH_MBS (MAX_WIDTH_MBS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pic_width (r_pic_width),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_q_pop     (w_q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    // Result word packing.
    assign m_axis_tdata = {6'b000000, w_res.pos_y, w_res.pos_x,
                           w_res.y_in_mb, w_res.x_in_mb, w_res.nb_mb_addr};
    assign m_axis_tuser = w_res.available;

endmodule

// File: rtl/mnl_chk.sv
// ----------------------------------------------------------------------------
// Macroblock neighbour locator port checker
// Watches the result stream of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "macroblock_neighbour_locator_unit_defines.svh"

module mnl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // An unavailable neighbour carries an all-zero word.
    `MNL_ASSERT_NOW(a_unavail_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "unavailable result with nonzero payload")

    // The absolute position keeps the parity of the position in the macroblock.
    `MNL_ASSERT_NOW(a_pos_parity, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[21] == m_axis_tdata[13]) && (m_axis_tdata[33] == m_axis_tdata[17]), "absolute position does not match position in macroblock")

    // A stalled result word holds.
    `MNL_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")

    // Reset empties the result buffer.
    `MNL_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid right after reset")

endmodule

bind macroblock_neighbour_locator_unit mnl_chk u_mnl_chk (.*);

// File: tb/neighbour_scoreboard.sv
// ----------------------------------------------------------------------------
// Neighbour locator scoreboard
// Watches both streams and the width register of the neighbour locator. It
// keeps its own picture width and prediction-direction store and works out
// the expected result word for every accepted query. Each accepted result
// word is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module neighbour_scoreboard
    import mnl_pkg::*;
#(
    parameter int MAX_MBS       = 8192,
    parameter int MAX_WIDTH_MBS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,
    input  logic [1:0]  i_in_kind,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [55:0] i_out_data,
    input  logic [0:0]  i_out_avail,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mismatch reports beyond this count are only counted.
    localparam int REPORT_CAP = 100;

    logic [8:0] width_mbs;
    bit   [1:0] dir_store [MAX_MBS*4];
    t_result    expected_neighbours [$];
    t_query     in_word;
    t_result    want;
    t_result    got;
    int         reports_shown;

    // Store slot of one 8x8 block; macroblock addresses wrap at the store size.
    function automatic int store_slot(input logic [ADDR_W-1:0] mb, input int blk);
        return (int'(mb) % MAX_MBS) * 4 + blk;
    endfunction

    // Expected result word of one pixel or 8x8 query.
    function automatic t_result locate_neighbour(input logic [1:0] kind, input t_query q);
        t_result           r;
        int                xn, yn, ext, xi, yi, w, px, py, sub_blk;
        logic [ADDR_W-1:0] nb;
        bit                av;
        logic [1:0]        own_dir, nb_dir;
        r   = '0;
        nb  = '0;
        av  = 1'b0;
        xn  = int'($signed(q.x_pos));
        yn  = int'($signed(q.y_pos));
        ext = (kind == KIND_PIX && !q.is_luma) ? 8 : 16;

        // An 8x8 query is taken relative to its block inside the macroblock.
        if (kind == KIND_BLK) begin
            xn = xn + 8 * int'(q.block8_index[0]);
            yn = yn + 8 * int'(q.block8_index[1]);
        end

        // Pick the neighbour macroblock from the signs and extents.
        if (xn < 0 && yn < 0) begin
            nb = q.upleft_addr;
            av = q.avail_mask[3];
        end else if (xn < 0 && yn < ext) begin
            nb = q.left_addr;
            av = q.avail_mask[0];
        end else if (xn < ext && yn < 0) begin
            nb = q.up_addr;
            av = q.avail_mask[1];
        end else if (xn < ext && yn < ext) begin
            nb = q.cur_mb_addr;
            av = 1'b1;
        end else if (yn < 0) begin
            nb = q.upright_addr;
            av = q.avail_mask[2];
        end
        if (!av) begin
            return r;
        end

        // Position inside the neighbour and in the picture.
        xi = xn & (ext - 1);
        yi = yn & (ext - 1);
        w  = int'(width_mbs);
        if (w < 1) begin
            w = 1;
        end
        if (w > MAX_WIDTH_MBS) begin
            w = MAX_WIDTH_MBS;
        end
        px = (int'(nb) % w) * ext + xi;
        py = (int'(nb) / w) * ext + yi;

        // Block queries drop conflicting directions and go to 8x8 units.
        if (kind == KIND_BLK) begin
            sub_blk = (xi >> 3) + 2 * (yi >> 3);
            own_dir = dir_store[store_slot(q.cur_mb_addr, int'(q.block8_index))];
            nb_dir  = dir_store[store_slot(nb, sub_blk)];
            if ((own_dir == DIR_FWD && nb_dir == DIR_BWD) ||
                (own_dir == DIR_BWD && nb_dir == DIR_FWD) ||
                (own_dir == DIR_SYM && nb_dir == DIR_BWD) ||
                (own_dir == DIR_BWD && nb_dir == DIR_SYM)) begin
                return r;
            end
            xi = xi >> 3;
            yi = yi >> 3;
            px = px >> 3;
            py = py >> 3;
        end

        r.available  = 1'b1;
        r.nb_mb_addr = nb;
        r.x_in_mb    = 4'(xi);
        r.y_in_mb    = 4'(yi);
        r.pos_x      = 12'(px);
        r.pos_y      = 17'(py);
        return r;
    endfunction

    // Compares one field of a result word and reports a difference.
    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            o_errors++;
            if (reports_shown < REPORT_CAP) begin
                reports_shown++;
                $display("%0t ns: %s differs, expected %0d, actual %0d",
                         $time, field, want_v, got_v);
            end
        end
    endtask

    // Track configuration, accepted input words and accepted result words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_mbs = 9'd120;
            expected_neighbours.delete();
        end else begin
            if (i_cfg_we) begin
                width_mbs = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                in_word.cur_mb_addr  = i_in_data[12:0];
                in_word.x_pos        = i_in_data[18:13];
                in_word.y_pos        = i_in_data[24:19];
                in_word.block8_index = i_in_data[26:25];
                in_word.is_luma      = i_in_data[27];
                in_word.left_addr    = i_in_data[40:28];
                in_word.up_addr      = i_in_data[53:41];
                in_word.upleft_addr  = i_in_data[66:54];
                in_word.upright_addr = i_in_data[79:67];
                in_word.avail_mask   = i_in_data[83:80];
                in_word.pdir_value   = i_in_data[85:84];
                if (i_in_kind == KIND_WR) begin
                    dir_store[store_slot(in_word.cur_mb_addr, int'(in_word.block8_index))] =
                        in_word.pdir_value;
                end else if (i_in_kind == KIND_PIX || i_in_kind == KIND_BLK) begin
                    expected_neighbours.push_back(locate_neighbour(i_in_kind, in_word));
                end
            end
            if (i_out_valid && i_out_ready) begin
                got.available  = i_out_avail[0];
                got.nb_mb_addr = i_out_data[12:0];
                got.x_in_mb    = i_out_data[16:13];
                got.y_in_mb    = i_out_data[20:17];
                got.pos_x      = i_out_data[32:21];
                got.pos_y      = i_out_data[49:33];
                o_results++;
                if (expected_neighbours.size() == 0) begin
                    o_errors++;
                    if (reports_shown < REPORT_CAP) begin
                        reports_shown++;
                        $display("%0t ns: result word without a query, expected none, actual %p",
                                 $time, got);
                    end
                end else begin
                    want = expected_neighbours.pop_front();
                    check_field("available", want.available, got.available);
                    check_field("nb_mb_addr", want.nb_mb_addr, got.nb_mb_addr);
                    check_field("x_in_mb", want.x_in_mb, got.x_in_mb);
                    check_field("y_in_mb", want.y_in_mb, got.y_in_mb);
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                end
            end
        end
        o_pending = expected_neighbours.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Neighbour locator testbench
// Drives directed and random words into the neighbour locator: pixel and 8x8
// queries, direction writes and ignored words, across several picture widths.
// Both stream sides idle at random, and the result side holds off once for a
// long stretch. The scoreboard beside the block does all the checking.
// ----------------------------------------------------------------------------
module tb
    import mnl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_IGNORED    = 2'd3;
    localparam int         PHASES          = 6;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam int         DRAIN_CYCLES    = 32;
    localparam int         HOLD_CYCLES     = 150;
    localparam int         HOLD_AFTER      = 300;
    localparam int         CYCLE_LIMIT     = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int          errors_seen;
    int          pending;
    int          results_checked;
    int          words_sent;
    int          query_count;
    int          write_count;
    int          ignored_count;
    int          width_writes;
    int          cycle_count;
    bit          hold_done;
    logic        calm_window;
    logic [12:0] mb_pool [$];

    // Neither side idles while this window of words goes through.
    assign calm_window = (words_sent >= 700) && (words_sent < 950);

    macroblock_neighbour_locator_unit #(
        .MAX_MBS       (8192),
        .MAX_WIDTH_MBS (256)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    neighbour_scoreboard #(
        .MAX_MBS       (8192),
        .MAX_WIDTH_MBS (256)
    ) u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_avail (m_axis_tuser),
        .o_errors    (errors_seen),
        .o_pending   (pending),
        .o_results   (results_checked)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: a run that has not finished by the limit fails.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, one long hold-off, and a calm window.
    initial begin
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && words_sent >= HOLD_AFTER) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (calm_window) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 38);
            end
        end
    end

    // Offers one word after a random idle gap and waits until it is taken.
    task automatic send_word(input logic [1:0] kind, input t_query q);
        while (!calm_window && ($urandom_range(0, 99) < 38)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, q.pdir_value, q.avail_mask, q.upright_addr,
                          q.upleft_addr, q.up_addr, q.left_addr, q.is_luma,
                          q.block8_index, q.y_pos, q.x_pos, q.cur_mb_addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        case (kind)
            KIND_WR:      write_count++;
            KIND_IGNORED: ignored_count++;
            default:      query_count++;
        endcase
    endtask

    // Any address, or one whose four direction entries are all written.
    function automatic logic [12:0] pick_address(input bit pooled);
        if (pooled) begin
            return mb_pool[$urandom_range(0, mb_pool.size() - 1)];
        end
        return 13'($urandom_range(0, 8191));
    endfunction

    // Offset mostly in the stated range, sometimes anywhere in six bits.
    function automatic logic signed [5:0] pick_offset(input bit near);
        if (near) begin
            return 6'($urandom_range(0, 17) - 9);
        end
        if ($urandom_range(0, 99) < 15) begin
            return 6'($urandom_range(0, 63));
        end
        return 6'($urandom_range(0, 31) - 8);
    endfunction

    function automatic t_query random_query(input bit pooled, input bit near);
        t_query q;
        q.cur_mb_addr  = pick_address(pooled);
        q.x_pos        = pick_offset(near);
        q.y_pos        = pick_offset(near);
        q.block8_index = 2'($urandom_range(0, 3));
        q.is_luma      = 1'($urandom_range(0, 1));
        q.left_addr    = pick_address(pooled);
        q.up_addr      = pick_address(pooled);
        q.upleft_addr  = pick_address(pooled);
        q.upright_addr = pick_address(pooled);
        q.avail_mask   = $urandom_range(0, 1) ? 4'hF : 4'($urandom_range(0, 15));
        q.pdir_value   = 2'($urandom_range(0, 3));
        return q;
    endfunction

    // Direction write with noise in the fields that writes do not use.
    task automatic send_dir(input logic [12:0] mb, input logic [1:0] blk,
                            input logic [1:0] dir);
        t_query q;
        q              = random_query(1'b0, 1'b0);
        q.cur_mb_addr  = mb;
        q.block8_index = blk;
        q.pdir_value   = dir;
        send_word(KIND_WR, q);
    endtask

    // Directed query; neighbour addresses stay within written macroblocks.
    task automatic probe(input logic [1:0] kind, input logic [12:0] cur,
                         input int x, input int y, input logic [1:0] blk,
                         input logic luma, input logic [3:0] mask);
        t_query q;
        q.cur_mb_addr  = cur;
        q.x_pos        = 6'(x);
        q.y_pos        = 6'(y);
        q.block8_index = blk;
        q.is_luma      = luma;
        q.left_addr    = 13'd8191;
        q.up_addr      = 13'd8191;
        q.upleft_addr  = 13'd8191;
        q.upright_addr = 13'd0;
        q.avail_mask   = mask;
        q.pdir_value   = DIR_SYM;
        send_word(kind, q);
    endtask

    // Waits for every expected word, then lets writes in flight settle.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        width_writes++;
    endtask

    // Stimulus and verdict.
    initial begin
        t_query      q;
        int          phase_width [PHASES];
        int          roll;
        int          budget;
        logic [12:0] mb;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        words_sent    = 0;
        query_count   = 0;
        write_count   = 0;
        ignored_count = 0;
        width_writes  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directions for the two extreme macroblocks, used by the block queries.
        send_dir(13'd0, 2'd0, DIR_FWD);
        send_dir(13'd0, 2'd1, DIR_BWD);
        send_dir(13'd0, 2'd2, DIR_SYM);
        send_dir(13'd0, 2'd3, 2'd3);
        send_dir(13'd8191, 2'd0, DIR_BWD);
        send_dir(13'd8191, 2'd1, DIR_FWD);
        send_dir(13'd8191, 2'd2, DIR_BWD);
        send_dir(13'd8191, 2'd3, DIR_SYM);
        mb_pool.push_back(13'd0);
        mb_pool.push_back(13'd8191);

        // Pixel queries: each neighbour, unavailable corners, chroma extent,
        // offsets beyond the stated range, and a masked-off neighbour.
        probe(KIND_PIX, 13'd0, -1, -1, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd0, -1, 5, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd0, 5, -1, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd8191, 15, 15, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd0, 16, -1, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd0, 16, 3, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd8191, 7, 7, 2'd0, 1'b0, 4'hF);
        probe(KIND_PIX, 13'd0, -8, -8, 2'd0, 1'b0, 4'h7);
        probe(KIND_PIX, 13'd0, 31, -32, 2'd0, 1'b1, 4'hF);
        probe(KIND_PIX, 13'd0, 23, 23, 2'd0, 1'b0, 4'hF);

        // Block queries: the direction conflicts and clean neighbours.
        probe(KIND_BLK, 13'd0, -1, 0, 2'd1, 1'b0, 4'hF);
        probe(KIND_BLK, 13'd8191, 0, 0, 2'd3, 1'b1, 4'hF);
        probe(KIND_BLK, 13'd0, -1, -1, 2'd0, 1'b1, 4'hF);
        probe(KIND_BLK, 13'd0, 0, -9, 2'd2, 1'b1, 4'hF);
        probe(KIND_BLK, 13'd8191, 8, 0, 2'd2, 1'b1, 4'hF);
        probe(KIND_BLK, 13'd8191, -8, 0, 2'd1, 1'b1, 4'hF);
        probe(KIND_IGNORED, 13'd8191, 3, 3, 2'd0, 1'b1, 4'hF);

        // Random phases, each under its own picture width.
        phase_width = '{1, 256, 0, 511, 45, 0};
        phase_width[PHASES-1] = $urandom_range(2, 255);
        for (int p = 0; p < PHASES; p++) begin
            settle_idle();
            write_width(9'(phase_width[p]));
            budget = 0;
            while (budget < ITEMS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    // Fresh macroblock: all four directions, then block queries on it.
                    mb = pick_address(1'b0);
                    for (int b = 0; b < 4; b++) begin
                        send_dir(mb, 2'(b), 2'($urandom_range(0, 3)));
                    end
                    mb_pool.push_back(mb);
                    for (int n = 0; n < 3; n++) begin
                        q = random_query(1'b1, 1'b1);
                        q.cur_mb_addr = mb;
                        send_word(KIND_BLK, q);
                    end
                    budget += 7;
                end else if (roll < 20) begin
                    q = random_query(1'b0, 1'b0);
                    if ($urandom_range(0, 9) < 7) begin
                        q.cur_mb_addr = pick_address(1'b1);
                    end
                    send_word(KIND_WR, q);
                    budget++;
                end else if (roll < 58) begin
                    send_word(KIND_PIX, random_query(1'b0, 1'b0));
                    budget++;
                end else if (roll < 96) begin
                    send_word(KIND_BLK, random_query(1'b1, $urandom_range(0, 9) < 7));
                    budget++;
                end else begin
                    send_word(KIND_IGNORED, random_query(1'b0, 1'b0));
                end
            end
        end
        settle_idle();

        $display("Sent %0d words: %0d queries, %0d direction writes, %0d ignored.",
                 words_sent, query_count, write_count, ignored_count);
        $display("Checked %0d result words over %0d picture widths, saturation included.",
                 results_checked, width_writes + 1);
        if (errors_seen == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
